// File: sv/fon_pkg.sv
// Shared widths, word types and helpers for the frame orthonormalisation core.
package fon_pkg;

   // Field and arithmetic widths.
   localparam int WordW     = 32;             // Q16.16 in, Q2.30 out
   localparam int AccW      = 36;             // projected columns before normalising
   localparam int FracShift = 30;             // binary point of a unit vector
   localparam int MagW      = FracShift + 1;  // normalised magnitude, below 2^31
   localparam int SqW       = 2 * MagW;       // one square
   localparam int SumW      = 64;             // sum of three squares
   localparam int RootW     = SumW / 2;       // integer square root
   localparam int NumW      = MagW + FracShift + 1;
   localparam int PrW       = 2 * WordW;      // one dot-product term
   localparam int RndW      = 66;             // rounded-shift operand

   // Pipeline depths.
   localparam int SqrtSteps = RootW;
   localparam int DivSteps  = MagW;
   localparam int NormLat   = 5 + SqrtSteps + 1 + DivSteps + 1;
   localparam int ProjLat   = 4;

   typedef logic [2:0][WordW-1:0] vec_type;
   typedef logic [2:0][AccW-1:0]  acc_vec_type;

   // Everything a word carries down the pipeline besides the unit in use.
   typedef struct packed {
      vec_type     v0;
      vec_type     v1;
      vec_type     v2;
      vec_type     pos;
      vec_type     e0;
      vec_type     e1;
      acc_vec_type u1;
      acc_vec_type u2;
   } item_type;

   // Sign-extend a Q16.16 column to the accumulator width.
   function automatic acc_vec_type widen(input vec_type v);
      acc_vec_type r;
      for (int i = 0; i < 3; i++) begin
         r[i] = {{(AccW-WordW){v[i][WordW-1]}}, v[i]};
      end
      return r;
   endfunction

endpackage

// File: sv/frame_orthonormalize_3x3_core.sv
// Throughput: one word per cycle while no result is stalled; three normalisers
// (70 stages each, set by the 32-stage square root and the 31-stage divider)
// and three 4-stage projectors.
// A stalled result freezes the whole pipeline; req_stall follows it.
// Reset clears the valid bits only; the data registers are not reset.
// Top level: Gram-Schmidt orthonormalisation of one 3x3 frame with translation.
module frame_orthonormalize_3x3_core import fon_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_col0_x,
   input  logic signed [31:0] req_col0_y,
   input  logic signed [31:0] req_col0_z,
   input  logic signed [31:0] req_col1_x,
   input  logic signed [31:0] req_col1_y,
   input  logic signed [31:0] req_col1_z,
   input  logic signed [31:0] req_col2_x,
   input  logic signed [31:0] req_col2_y,
   input  logic signed [31:0] req_col2_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_ortho_c0_x,
   output logic signed [31:0] rsp_ortho_c0_y,
   output logic signed [31:0] rsp_ortho_c0_z,
   output logic signed [31:0] rsp_ortho_c1_x,
   output logic signed [31:0] rsp_ortho_c1_y,
   output logic signed [31:0] rsp_ortho_c1_z,
   output logic signed [31:0] rsp_ortho_c2_x,
   output logic signed [31:0] rsp_ortho_c2_y,
   output logic signed [31:0] rsp_ortho_c2_z,
   output logic signed [31:0] rsp_pos_out_x,
   output logic signed [31:0] rsp_pos_out_y,
   output logic signed [31:0] rsp_pos_out_z
);

   logic        adv;
   item_type    in_item;
   logic        n0_vld, pa_vld, pb_vld, n1_vld, pc_vld, n2_vld;
   vec_type     n0_e, n1_e, n2_e;
   acc_vec_type pa_acc, pb_acc, pc_acc;
   item_type    n0_item, pa_item, pb_item, n1_item, pc_item, n2_item;
   item_type    pa_src, pb_src, n1_src, pc_src, n2_src;

   // The pipeline moves unless a finished word is held at the output.
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Incoming word.
   always_comb begin
      in_item        = '0;
      in_item.v0     = {req_col0_z, req_col0_y, req_col0_x};
      in_item.v1     = {req_col1_z, req_col1_y, req_col1_x};
      in_item.v2     = {req_col2_z, req_col2_y, req_col2_x};
      in_item.pos    = {req_pos_z, req_pos_y, req_pos_x};
   end

   // First column.
   fon_norm u_norm0 (
      .clock, .reset, .adv,
      .in_vld   (req_valid),
      .in_c     (widen(in_item.v0)),
      .in_item  (in_item),
      .out_vld  (n0_vld),
      .out_e    (n0_e),
      .out_item (n0_item)
   );

   always_comb begin
      pa_src    = n0_item;
      pa_src.e0 = n0_e;
   end

   // Second column less its projection on the first unit vector.
   fon_proj u_proj_a (
      .clock, .reset, .adv,
      .in_vld   (n0_vld),
      .in_e     (pa_src.e0),
      .in_v     (pa_src.v1),
      .in_acc   (widen(pa_src.v1)),
      .in_item  (pa_src),
      .out_vld  (pa_vld),
      .out_acc  (pa_acc),
      .out_item (pa_item)
   );

   always_comb begin
      pb_src    = pa_item;
      pb_src.u1 = pa_acc;
   end

   // Third column less its projection on the first unit vector.
   fon_proj u_proj_b (
      .clock, .reset, .adv,
      .in_vld   (pa_vld),
      .in_e     (pb_src.e0),
      .in_v     (pb_src.v2),
      .in_acc   (widen(pb_src.v2)),
      .in_item  (pb_src),
      .out_vld  (pb_vld),
      .out_acc  (pb_acc),
      .out_item (pb_item)
   );

   always_comb begin
      n1_src    = pb_item;
      n1_src.u2 = pb_acc;
   end

   // Second unit vector.
   fon_norm u_norm1 (
      .clock, .reset, .adv,
      .in_vld   (pb_vld),
      .in_c     (n1_src.u1),
      .in_item  (n1_src),
      .out_vld  (n1_vld),
      .out_e    (n1_e),
      .out_item (n1_item)
   );

   always_comb begin
      pc_src    = n1_item;
      pc_src.e1 = n1_e;
   end

   // Remove the projection of the third column on the second unit vector.
   fon_proj u_proj_c (
      .clock, .reset, .adv,
      .in_vld   (n1_vld),
      .in_e     (pc_src.e1),
      .in_v     (pc_src.v2),
      .in_acc   (pc_src.u2),
      .in_item  (pc_src),
      .out_vld  (pc_vld),
      .out_acc  (pc_acc),
      .out_item (pc_item)
   );

   always_comb begin
      n2_src    = pc_item;
      n2_src.u2 = pc_acc;
   end

   // Third unit vector; its output stage is the result register.
   fon_norm u_norm2 (
      .clock, .reset, .adv,
      .in_vld   (pc_vld),
      .in_c     (n2_src.u2),
      .in_item  (n2_src),
      .out_vld  (n2_vld),
      .out_e    (n2_e),
      .out_item (n2_item)
   );

   // Result word.
   assign rsp_valid      = n2_vld;
   assign rsp_ortho_c0_x = n2_item.e0[0];
   assign rsp_ortho_c0_y = n2_item.e0[1];
   assign rsp_ortho_c0_z = n2_item.e0[2];
   assign rsp_ortho_c1_x = n2_item.e1[0];
   assign rsp_ortho_c1_y = n2_item.e1[1];
   assign rsp_ortho_c1_z = n2_item.e1[2];
   assign rsp_ortho_c2_x = n2_e[0];
   assign rsp_ortho_c2_y = n2_e[1];
   assign rsp_ortho_c2_z = n2_e[2];
   assign rsp_pos_out_x  = n2_item.pos[0];
   assign rsp_pos_out_y  = n2_item.pos[1];
   assign rsp_pos_out_z  = n2_item.pos[2];

endmodule

// File: sv/fon_proj.sv
// Pipelined subtraction of the projection of a column onto a unit vector.
module fon_proj import fon_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_vld,
   input  vec_type     in_e,
   input  vec_type     in_v,
   input  acc_vec_type in_acc,
   input  item_type    in_item,
   output logic        out_vld,
   output acc_vec_type out_acc,
   output item_type    out_item
);

   typedef struct packed {
      logic [2:0][PrW-1:0] p;
      vec_type             e;
      acc_vec_type         acc;
      item_type            item;
   } prod_st_type;

   typedef struct packed {
      logic [AccW-1:0] d;
      vec_type         e;
      acc_vec_type     acc;
      item_type        item;
   } dot_st_type;

   typedef struct packed {
      logic [2:0][RndW-1:0] pr;
      acc_vec_type          acc;
      item_type             item;
   } scl_st_type;

   typedef struct packed {
      acc_vec_type acc;
      item_type    item;
   } sub_st_type;

   prod_st_type a_ff, a_in;
   dot_st_type  b_ff, b_in;
   scl_st_type  c_ff, c_in;
   sub_st_type  d_ff, d_in;
   logic [ProjLat-1:0] vld_ff, vld_in;

   // Shift right by the binary point, rounding half away from zero.
   function automatic logic [AccW-1:0] round_q30(input logic [RndW-1:0] x);
      logic [RndW-1:0] mag;
      logic [RndW-1:0] r;
      mag = x[RndW-1] ? (~x + 1'b1) : x;
      r   = (mag + (RndW'(1) << (FracShift - 1))) >> FracShift;
      return x[RndW-1] ? AccW'(~r + 1'b1) : AccW'(r);
   endfunction

   // Stage one: the three exact products of the dot product.
   always_comb begin
      logic signed [PrW-1:0] prod;
      a_in.e    = in_e;
      a_in.acc  = in_acc;
      a_in.item = in_item;
      for (int i = 0; i < 3; i++) begin
         prod      = $signed(in_e[i]) * $signed(in_v[i]);
         a_in.p[i] = prod;
      end
   end

   // Stage two: sum the products and round to Q16.16.
   always_comb begin
      logic signed [RndW-1:0] sum;
      sum = $signed(a_ff.p[0]) + $signed(a_ff.p[1]) + $signed(a_ff.p[2]);
      b_in.d    = round_q30(sum);
      b_in.e    = a_ff.e;
      b_in.acc  = a_ff.acc;
      b_in.item = a_ff.item;
   end

   // Stage three: scale the unit vector by the dot product.
   always_comb begin
      logic signed [AccW+WordW-1:0] prod;
      c_in.acc  = b_ff.acc;
      c_in.item = b_ff.item;
      for (int i = 0; i < 3; i++) begin
         prod       = $signed(b_ff.d) * $signed(b_ff.e[i]);
         c_in.pr[i] = prod[RndW-1:0];
      end
   end

   // Stage four: round each term and subtract it.
   always_comb begin
      d_in.item = c_ff.item;
      for (int i = 0; i < 3; i++) begin
         d_in.acc[i] = c_ff.acc[i] - round_q30(c_ff.pr[i]);
      end
   end

   assign vld_in = {vld_ff[ProjLat-2:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
      end
   end

   assign out_vld  = vld_ff[ProjLat-1];
   assign out_acc  = d_ff.acc;
   assign out_item = d_ff.item;

endmodule

// File: sv/fon_norm.sv
// Pipelined normalisation of one column to a Q2.30 unit vector.
module fon_norm import fon_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_vld,
   input  acc_vec_type in_c,
   input  item_type    in_item,
   output logic        out_vld,
   output vec_type     out_e,
   output item_type    out_item
);

   localparam int PosW = $clog2(AccW);

   typedef struct packed {
      logic [2:0][AccW-1:0] mag;
      logic [2:0]           neg;
      item_type             item;
   } mag_st_type;

   typedef struct packed {
      logic [2:0][AccW-1:0] mag;
      logic [2:0]           neg;
      logic [AccW-1:0]      mx;
      item_type             item;
   } max_st_type;

   typedef struct packed {
      logic [2:0][MagW-1:0] m;
      logic [2:0]           neg;
      logic                 zero;
      item_type             item;
   } sh_st_type;

   typedef struct packed {
      logic [2:0][SqW-1:0]  sq;
      logic [2:0][MagW-1:0] m;
      logic [2:0]           neg;
      logic                 zero;
      item_type             item;
   } sq_st_type;

   typedef struct packed {
      logic [SumW-1:0]      s;
      logic [SumW-1:0]      res;
      logic [2:0][MagW-1:0] m;
      logic [2:0]           neg;
      logic                 zero;
      item_type             item;
   } rt_st_type;

   typedef struct packed {
      logic [RootW-1:0]       n;
      logic [2:0][RootW-1:0]  r;
      logic [2:0][MagW-1:0]   low;
      logic [2:0][MagW-1:0]   q;
      logic [2:0]             neg;
      logic                   zero;
      item_type               item;
   } dv_st_type;

   mag_st_type a_ff, a_in;
   max_st_type b_ff, b_in;
   sh_st_type  c_ff, c_in;
   sq_st_type  d_ff, d_in;
   rt_st_type  s_ff, s_in;
   rt_st_type  rt_ff  [0:SqrtSteps-1];
   rt_st_type  rt_in  [0:SqrtSteps-1];
   rt_st_type  rt_src [0:SqrtSteps-1];
   dv_st_type  f_ff, f_in;
   dv_st_type  dv_ff  [0:DivSteps-1];
   dv_st_type  dv_in  [0:DivSteps-1];
   dv_st_type  dv_src [0:DivSteps-1];
   vec_type    g_ff, g_in;
   item_type   g_item_ff;
   logic [NormLat-1:0] vld_ff, vld_in;

   // Magnitudes and signs of the components.
   always_comb begin
      a_in.item = in_item;
      for (int i = 0; i < 3; i++) begin
         a_in.neg[i] = in_c[i][AccW-1];
         a_in.mag[i] = in_c[i][AccW-1] ? (~in_c[i] + 1'b1) : in_c[i];
      end
   end

   // Largest magnitude.
   always_comb begin
      logic [AccW-1:0] m01;
      m01       = (a_ff.mag[0] > a_ff.mag[1]) ? a_ff.mag[0] : a_ff.mag[1];
      b_in.mx   = (m01 > a_ff.mag[2]) ? m01 : a_ff.mag[2];
      b_in.mag  = a_ff.mag;
      b_in.neg  = a_ff.neg;
      b_in.item = a_ff.item;
   end

   // Bring the largest magnitude into [2^30, 2^31); right shifts truncate.
   always_comb begin
      logic [PosW-1:0] pos;
      logic [AccW-1:0] sh;
      pos = '0;
      for (int i = 0; i < AccW; i++) begin
         if (b_ff.mx[i]) begin
            pos = PosW'(i);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (pos < PosW'(FracShift)) begin
            sh = b_ff.mag[i] << (PosW'(FracShift) - pos);
         end else begin
            sh = b_ff.mag[i] >> (pos - PosW'(FracShift));
         end
         c_in.m[i] = sh[MagW-1:0];
      end
      c_in.zero = (b_ff.mx == '0);
      c_in.neg  = b_ff.neg;
      c_in.item = b_ff.item;
   end

   // Squares.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in.sq[i] = SqW'(c_ff.m[i]) * SqW'(c_ff.m[i]);
      end
      d_in.m    = c_ff.m;
      d_in.neg  = c_ff.neg;
      d_in.zero = c_ff.zero;
      d_in.item = c_ff.item;
   end

   // Sum of squares; the root starts from zero.
   always_comb begin
      s_in.s    = SumW'(d_ff.sq[0]) + SumW'(d_ff.sq[1]) + SumW'(d_ff.sq[2]);
      s_in.res  = '0;
      s_in.m    = d_ff.m;
      s_in.neg  = d_ff.neg;
      s_in.zero = d_ff.zero;
      s_in.item = d_ff.item;
   end

   // Integer square root, one result bit per stage.
   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      localparam logic [SumW-1:0] StepBit = SumW'(1) << (SumW - 2 - 2 * k);
      logic [SumW-1:0] trial;

      if (k == 0) begin : g_first
         assign rt_src[k] = s_ff;
      end else begin : g_next
         assign rt_src[k] = rt_ff[k-1];
      end

      assign trial = rt_src[k].res + StepBit;

      always_comb begin
         rt_in[k] = rt_src[k];
         if (rt_src[k].s >= trial) begin
            rt_in[k].s   = rt_src[k].s - trial;
            rt_in[k].res = (rt_src[k].res >> 1) + StepBit;
         end else begin
            rt_in[k].res = rt_src[k].res >> 1;
         end
      end
   end

   // Rounded dividend m * 2^30 + n / 2, split into the starting remainder and low bits.
   always_comb begin
      logic [NumW-1:0] num;
      f_in.n = rt_ff[SqrtSteps-1].res[RootW-1:0];
      for (int i = 0; i < 3; i++) begin
         num = (NumW'(rt_ff[SqrtSteps-1].m[i]) << FracShift) + NumW'(f_in.n >> 1);
         f_in.r[i]   = RootW'(num[NumW-1:MagW]);
         f_in.low[i] = num[MagW-1:0];
      end
      f_in.q    = '0;
      f_in.neg  = rt_ff[SqrtSteps-1].neg;
      f_in.zero = rt_ff[SqrtSteps-1].zero;
      f_in.item = rt_ff[SqrtSteps-1].item;
   end

   // Restoring division of the three components by the root, one bit per stage.
   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      if (k == 0) begin : g_first
         assign dv_src[k] = f_ff;
      end else begin : g_next
         assign dv_src[k] = dv_ff[k-1];
      end

      always_comb begin
         logic [RootW:0] t;
         logic [RootW:0] diff;
         dv_in[k] = dv_src[k];
         for (int i = 0; i < 3; i++) begin
            t    = {dv_src[k].r[i], dv_src[k].low[i][MagW-1]};
            diff = t - {1'b0, dv_src[k].n};
            dv_in[k].low[i] = dv_src[k].low[i] << 1;
            if (t >= {1'b0, dv_src[k].n}) begin
               dv_in[k].r[i] = diff[RootW-1:0];
               dv_in[k].q[i] = {dv_src[k].q[i][MagW-2:0], 1'b1};
            end else begin
               dv_in[k].r[i] = t[RootW-1:0];
               dv_in[k].q[i] = {dv_src[k].q[i][MagW-2:0], 1'b0};
            end
         end
      end
   end

   // Restore signs; a zero column stays zero.
   always_comb begin
      logic [WordW-1:0] qw;
      for (int i = 0; i < 3; i++) begin
         qw = WordW'(dv_ff[DivSteps-1].q[i]);
         if (dv_ff[DivSteps-1].zero) begin
            g_in[i] = '0;
         end else if (dv_ff[DivSteps-1].neg[i]) begin
            g_in[i] = ~qw + 1'b1;
         end else begin
            g_in[i] = qw;
         end
      end
   end

   assign vld_in = {vld_ff[NormLat-2:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         s_ff <= s_in;
         for (int k = 0; k < SqrtSteps; k++) begin
            rt_ff[k] <= rt_in[k];
         end
         f_ff <= f_in;
         for (int k = 0; k < DivSteps; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         g_ff      <= g_in;
         g_item_ff <= dv_ff[DivSteps-1].item;
      end
   end

   assign out_vld  = vld_ff[NormLat-1];
   assign out_e    = g_ff;
   assign out_item = g_item_ff;

endmodule

// File: sv/fon_checker.sv
// Port-level checks for the orthonormalisation core, bound to the top level.
module fon_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_ortho_c0_x,
   input logic signed [31:0] rsp_ortho_c1_y,
   input logic signed [31:0] rsp_ortho_c2_z,
   input logic signed [31:0] rsp_pos_out_x
);

   // No result word is presented straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // The input is held back exactly when a result word is held at the output.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

   // A stalled result word stays valid, and its c2 z and pos x fields hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ortho_c2_z)
         && $stable(rsp_pos_out_x))
      else $error("stalled result word changed");

   // Unit vector components c0 x, c1 y and c2 z stay within plus or minus one.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ortho_c0_x <= 32'sd1073741824
         && rsp_ortho_c0_x >= -32'sd1073741824
         && rsp_ortho_c1_y <= 32'sd1073741824
         && rsp_ortho_c1_y >= -32'sd1073741824
         && rsp_ortho_c2_z <= 32'sd1073741824
         && rsp_ortho_c2_z >= -32'sd1073741824)
      else $error("unit vector component out of range");

endmodule

bind frame_orthonormalize_3x3_core fon_checker u_fon_checker (.*);
